[design/tst_pkg.sv]
// tst_pkg: shared types and constants for the timeout slot table.
// Holds command codes, field widths and the controller/datapath bundles.
// No dependencies.
package tst_pkg;

    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 4;
    localparam int TIME_W    = 32;
    localparam int SLOT_SPAN = 16;   // slots reachable through the 4-bit slot field

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ARM   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEEK = 3'b010,
        ST_READ = 3'b100
    } tst_state_t;

    // controller -> datapath
    typedef struct packed {
        logic do_tick;
        logic do_arm;
        logic clr_idx;
        logic inc_idx;
        logic load_out;
    } tst_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic armed_cur;   // slot under the sweep index is armed
        logic idx_end;     // sweep index on the final slot
        logic is_last;     // no armed slot above the sweep index
        logic out_free;    // output register can take a beat
    } tst_sts_t;

endpackage

[design/tst_ram.sv]
// tst_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/tst_ctrl.sv]
// tst_ctrl: command decode and sweep sequencer for the timeout slot table.
// Depends on tst_pkg; drives tst_dp through tst_cmd_t, reads tst_sts_t.
module tst_ctrl
    import tst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] command,
    output logic             in_ready,
    input  tst_sts_t         sts,
    output tst_cmd_t         cmd
);

    tst_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (command)
                        CMD_TICK:  cmd.do_tick = 1'b1;
                        CMD_ARM:   cmd.do_arm  = 1'b1;
                        CMD_CHECK:
                        begin
                            cmd.clr_idx = 1'b1;
                            state_next  = ST_SEEK;
                        end
                        default: ;   // unused code: beat dropped
                    endcase
                end
            end
            ST_SEEK:
            begin
                // read issued for the current index; data lands next cycle
                if (sts.armed_cur)
                begin
                    state_next = ST_READ;
                end
                else if (sts.idx_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                end
            end
            ST_READ:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.inc_idx = 1'b1;
                        state_next  = ST_SEEK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/tst_dp.sv]
// tst_dp: tick counter, armed flags, deadline RAM, sweep index and output register.
// Depends on tst_pkg and tst_ram; steered by tst_ctrl.
module tst_dp
    import tst_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tst_cmd_t          cmd,
    output tst_sts_t          sts,
    input  logic [SLOT_W-1:0] slot,
    input  logic [TIME_W-1:0] timeout_ms,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SLOT_W-1:0] slot_id,
    output logic              expired,
    output logic              last
);

    localparam int SPAN  = (NUM_SLOTS < SLOT_SPAN) ? NUM_SLOTS : SLOT_SPAN;
    localparam int IDX_W = (SPAN > 1) ? $clog2(SPAN) : 1;

    logic [TIME_W-1:0] tick_reg, tick_next;
    logic [SPAN-1:0]   armed_reg, armed_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [SLOT_W-1:0] slot_id_reg;
    logic              expired_reg;
    logic              last_reg;

    logic [TIME_W-1:0] rd_deadline;
    logic              arm_ok;
    logic              fired;
    logic              above;

    assign arm_ok = ({{(TIME_W-SLOT_W){1'b0}}, slot} < TIME_W'(NUM_SLOTS));
    assign fired  = (rd_deadline <= tick_reg);

    tst_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SPAN)
    ) u_deadline (
        .clk     (clk),
        .wr_en   (cmd.do_arm && arm_ok),
        .wr_addr (IDX_W'(slot)),
        .wr_data (tick_reg + timeout_ms),
        .rd_addr (idx_reg),
        .rd_data (rd_deadline)
    );

    // any armed slot beyond the current index
    always_comb
    begin
        above = 1'b0;
        for (int j = 0; j < SPAN; j++)
        begin
            if (armed_reg[j] && (IDX_W'(j) > idx_reg))
            begin
                above = 1'b1;
            end
        end
    end

    assign sts.armed_cur = armed_reg[idx_reg];
    assign sts.idx_end   = (idx_reg == IDX_W'(SPAN - 1));
    assign sts.is_last   = !above;
    assign sts.out_free  = !valid_reg || out_ready;

    always_comb
    begin
        tick_next  = tick_reg;
        armed_next = armed_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (cmd.do_tick)
        begin
            tick_next = tick_reg + 1'b1;
        end
        if (cmd.do_arm && arm_ok)
        begin
            armed_next[IDX_W'(slot)] = 1'b1;
        end
        if (cmd.load_out)
        begin
            valid_next = 1'b1;
            if (fired)
            begin
                armed_next[idx_reg] = 1'b0;
            end
        end
        if (cmd.clr_idx)
        begin
            idx_next = '0;
        end
        else if (cmd.inc_idx)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            armed_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tick_reg  <= tick_next;
            armed_reg <= armed_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            slot_id_reg <= SLOT_W'(idx_reg);
            expired_reg <= fired;
            last_reg    <= !above;
        end
    end

    assign out_valid = valid_reg;
    assign slot_id   = slot_id_reg;
    assign expired   = expired_reg;
    assign last      = last_reg;

endmodule

[design/timeout_slot_table_top.sv]
// timeout_slot_table_top: tick-driven timeout slot table; tst_ctrl sequences tst_dp.
// A sweep starts from idle, steps the sweep index over each unarmed slot and adds a read state
//   (deadline RAM read) for each armed slot, up to the highest armed slot; later slots are
//   skipped, an empty sweep walks every slot, and output stalls hold the sweep.
// Throughput: one tick/arm beat per cycle; s_tready is low during a sweep.
// Reset (rst_n, async, low): tick = 0, slots disarmed, no beat pending, deadline RAM kept.
module timeout_slot_table_top
    import tst_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] slot, [35:4] timeout_ms, [39:36] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] slot_id, [4] expired, [7:5] zero
    output logic        m_tlast    // final result of a sweep
);

    tst_cmd_t          cmd;
    tst_sts_t          sts;
    logic [SLOT_W-1:0] slot_id;
    logic              expired;

    // sequencer: decodes commands, walks the slots in order and takes no new command during a sweep
    tst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .command  (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: tick counter, armed flags, deadline RAM, output register
    tst_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .slot       (s_tdata[3:0]),
        .timeout_ms (s_tdata[35:4]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .slot_id    (slot_id),
        .expired    (expired),
        .last       (m_tlast)
    );

    assign m_tdata = {3'b000, expired, slot_id};

endmodule

[tb/sv/tst_sweep_checker.sv]
`timescale 1ns / 100ps
// tst_sweep_checker: shadow model and scoreboard for timeout_slot_table_top.
// Watches both stream channels, predicts sweep reports and compares them.
// Depends on tst_pkg.
module tst_sweep_checker
    import tst_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          reports_due
);

    typedef struct packed {
        logic [SLOT_W-1:0] slot_id;
        logic              expired;
        logic              last;
    } slot_report_t;

    logic [TIME_W-1:0]    tick_now;
    logic [TIME_W-1:0]    due_tick [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_armed;
    slot_report_t         report_q [$];

    // Apply one accepted command to the shadow table; a check sweep queues
    // one report per armed slot, lowest slot first.
    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic [SLOT_W-1:0] slot,
                                 input logic [TIME_W-1:0] timeout_ms);
        slot_report_t rep;
        int           last_idx;
        last_idx = -1;
        case (cmd)
            CMD_TICK: tick_now = tick_now + 1'b1;
            CMD_ARM:
                if (slot < NUM_SLOTS)
                begin
                    due_tick[slot]   = tick_now + timeout_ms;
                    slot_armed[slot] = 1'b1;
                end
            CMD_CHECK:
            begin
                for (int i = 0; i < NUM_SLOTS && i < SLOT_SPAN; i++)
                begin
                    if (slot_armed[i])
                    begin
                        rep.slot_id = SLOT_W'(i);
                        // plain unsigned compare, wrap not handled
                        rep.expired = (due_tick[i] <= tick_now);
                        rep.last    = 1'b0;
                        if (rep.expired)
                            slot_armed[i] = 1'b0;
                        report_q.push_back(rep);
                        last_idx = report_q.size() - 1;
                    end
                end
                if (last_idx >= 0)
                    report_q[last_idx].last = 1'b1;
            end
            default: ;  // unused command: no effect
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        slot_report_t want;
        int           errs;
        if (!rst_n)
        begin
            tick_now    = '0;
            slot_armed  = '0;
            report_q.delete();
            fail_count  <= 0;
            reports_due <= 0;
        end
        else
        begin
            errs = 0;
            // result side first: a new sweep may be accepted on the same edge
            if (m_tvalid && m_tready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("unexpected result beat: slot_id %0d expired %0b last %0b",
                           m_tdata[3:0], m_tdata[4], m_tlast);
                    errs++;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (m_tdata[3:0] !== want.slot_id)
                    begin
                        $error("slot_id: expected %0d, actual %0d", want.slot_id, m_tdata[3:0]);
                        errs++;
                    end
                    if (m_tdata[4] !== want.expired)
                    begin
                        $error("expired: expected %0b, actual %0b", want.expired, m_tdata[4]);
                        errs++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_command(s_tuser, s_tdata[3:0], s_tdata[35:4]);
            fail_count  <= fail_count + errs;
            reports_due <= report_q.size();
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// tb: top-level testbench for timeout_slot_table_top.
// Drives the command stream, throttles the result stream and gives the verdict;
// checking lives in tst_sweep_checker. Depends on tst_pkg.
module tb;
    import tst_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int RANDOM_BEATS = 350;
    localparam int IDLE_LIMIT   = 3000;   // cycles with no beat on either channel
    localparam int HOLD_CYCLES  = 300;    // long result-side stall
    localparam int DRAIN_CYCLES = 40;     // margin after last report, longer than a worst-case unstalled sweep

    // command 3 is not decoded by the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // [3:0] slot, [35:4] timeout_ms, [39:36] zero
    logic [1:0]  s_tuser;    // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [3:0] slot_id, [4] expired, [7:5] zero
    logic        m_tlast;

    int          fail_count;
    int          reports_due;
    int          burst_left;
    logic        hold_req;   // stimulus asks the receiver for one long stall

    timeout_slot_table_top #(
        .NUM_SLOTS(NUM_SLOTS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    tst_sweep_checker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .reports_due(reports_due)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one command beat. Called at a falling edge, returns at a falling
    // edge. The sender runs in bursts; between bursts valid drops for a random
    // gap, and some bursts follow each other with no gap at all.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd,
                            input logic [SLOT_W-1:0] slot,
                            input logic [TIME_W-1:0] timeout_ms);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, timeout_ms, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // Timeout lengths biased short so deadlines actually get reached,
    // with full-range and near-wrap values mixed in.
    function automatic logic [TIME_W-1:0] pick_timeout();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return $urandom_range(0, 8);
        else if (sel < 80)
            return $urandom_range(0, 64);
        else if (sel < 95)
            return $urandom;
        else
            return 32'hFFFF_FFFF - $urandom_range(0, 4);
    endfunction

    // Result-side throttle: modes of always-ready, mostly-ready and
    // mostly-stalled, plus one long hold-off on request.
    initial
    begin : receiver
        int mode;
        int mode_left;
        bit hold_served;
        mode        = 0;
        mode_left   = 0;
        hold_served = 0;
        m_tready    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_served)
            begin
                // block stalls on the stuck report and drops s_tready
                hold_served = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: ends the run when neither channel moves a beat for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [CMD_W-1:0] cmd;
        int               roll;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        rst_n      = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed part ---
        send_cmd(CMD_CHECK, 4'h0, '0);             // empty sweep: no report
        send_cmd(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF); // unused command: ignored
        send_cmd(CMD_ARM, 4'h0, '0);               // due at once
        send_cmd(CMD_ARM, 4'hF, 32'hFFFF_FFFF);    // farthest deadline
        send_cmd(CMD_ARM, 4'h5, 32'd2);
        send_cmd(CMD_CHECK, 4'hA, 32'h1234_5678);  // 0 fires, 5 and 15 pending
        send_cmd(CMD_TICK, 4'hF, 32'hFFFF_FFFF);   // fields ignored on a tick
        send_cmd(CMD_TICK, 4'h0, '0);
        send_cmd(CMD_CHECK, 4'h0, '0);             // 5 fires, 15 pending
        send_cmd(CMD_ARM, 4'hF, 32'd1);            // re-arm with a short deadline
        send_cmd(CMD_ARM, 4'h9, 32'hFFFF_FFFF);    // deadline wraps past zero
        send_cmd(CMD_ARM, 4'hA, 32'hAAAA_AAAA);
        send_cmd(CMD_ARM, 4'h6, 32'h5555_5555);
        send_cmd(CMD_CHECK, 4'h0, '0);             // wrapped slot 9 fires at once
        send_cmd(CMD_TICK, 4'h0, '0);
        send_cmd(CMD_CHECK, 4'h0, '0);             // re-armed slot 15 fires

        // --- full table under a long result stall ---
        hold_req = 1'b1;
        for (int i = 0; i < SLOT_SPAN; i++)
            send_cmd(CMD_ARM, SLOT_W'(i), $urandom_range(0, 3));
        send_cmd(CMD_CHECK, 4'h0, '0);             // 16 reports, input backs up
        send_cmd(CMD_TICK, 4'h0, '0);
        send_cmd(CMD_TICK, 4'h0, '0);
        send_cmd(CMD_CHECK, 4'h0, '0);
        send_cmd(CMD_ARM, 4'h3, 32'd1);
        send_cmd(CMD_CHECK, 4'h0, '0);

        // --- random part: mostly meaningful commands, a little junk ---
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 38)
                cmd = CMD_TICK;
            else if (roll < 72)
                cmd = CMD_ARM;
            else if (roll < 95)
                cmd = CMD_CHECK;
            else
                cmd = CMD_UNUSED;
            send_cmd(cmd, SLOT_W'($urandom_range(0, 15)), pick_timeout());
        end
        s_tvalid <= 1'b0;

        // drain: all reports in, then let any late beat show up
        while (reports_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && reports_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
design/tst_pkg.sv
design/tst_ram.sv
design/tst_ctrl.sv
design/tst_dp.sv
design/timeout_slot_table_top.sv
tb/sv/tst_sweep_checker.sv
tb/sv/tb.sv
